>>> hdl/kms_pkg.sv
// Shared types, constants and the scan-order table for the key matrix scanner.
// No dependencies; every other file in hdl/ imports this package.
package kms_pkg;

  // Matrix geometry
  localparam int COLUMNS         = 8;
  localparam int COL_W           = $clog2(COLUMNS);
  localparam int LINES           = 32;
  localparam int LINE_W          = $clog2(LINES);
  localparam int LINES_PER_MAN   = 8;
  localparam int KEYS_PER_MANUAL = 64;
  localparam int KEY_W           = $clog2(KEYS_PER_MANUAL);

  // Manual whose keys run along the column instead of across it (manual 3)
  localparam logic [1:0] MAN_COLWISE = 2'd2;

  // Event kinds
  localparam logic [1:0] EV_NOTE_OFF = 2'd0;
  localparam logic [1:0] EV_NOTE_ON  = 2'd1;
  localparam logic [1:0] EV_CC       = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_BASE_NOTE  = 3'd0;
  localparam logic [2:0] REG_ON_VEL     = 3'd1;
  localparam logic [2:0] REG_CC_NUMBER  = 3'd2;
  localparam logic [2:0] REG_CC_CHANNEL = 3'd3;
  localparam logic [2:0] REG_DEADBAND   = 3'd4;

  // Register reset values
  localparam logic [6:0] RST_BASE_NOTE  = 7'd36;
  localparam logic [6:0] RST_ON_VEL     = 7'd100;
  localparam logic [6:0] RST_CC_NUMBER  = 7'd16;
  localparam logic [4:0] RST_CC_CHANNEL = 5'd1;
  localparam logic [9:0] RST_DEADBAND   = 10'd5;

  // Settings used by the event builder
  typedef struct packed {
    logic [6:0] base_note;
    logic [6:0] on_velocity;
    logic [6:0] cc_number;
    logic [4:0] cc_channel;
  } cfg_t;

  // One queued scan step; mask and level are in emission order
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [LINES-1:0] mask;
    logic [LINES-1:0] level;
    logic             pedal_evt;
    logic [6:0]       cc_value;
  } q_entry_t;

  // For each column: data line emitted at each slot of the sorted order
  typedef logic [COLUMNS-1:0][LINES-1:0][LINE_W-1:0] line_tab_t;

  // Sort key of one data line: key index first, then manual
  function automatic int sort_key(int c, int n);
    int m;
    int k;
    int key;
    m   = n / LINES_PER_MAN;
    k   = n % LINES_PER_MAN;
    key = (m == int'(MAN_COLWISE)) ? LINES_PER_MAN * c + k : c + LINES_PER_MAN * k;
    return key * 4 + m;
  endfunction

  // Rank every line under the sort key, per column
  function automatic line_tab_t build_line_tab();
    line_tab_t t;
    int        rank;
    int        sa;
    t = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      for (int n = 0; n < LINES; n++) begin
        sa   = sort_key(c, n);
        rank = 0;
        for (int n2 = 0; n2 < LINES; n2++) begin
          if (sort_key(c, n2) < sa) rank++;
        end
        t[c][rank] = LINE_W'(n);
      end
    end
    return t;
  endfunction

  localparam line_tab_t LINE_TAB = build_line_tab();

endpackage

>>> hdl/kms_if.sv
// Valid/ready channel interfaces for scan steps in and note events out.
// Depends on kms_pkg for field widths.
interface kms_in_if
  import kms_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [LINES-1:0] row_bits;
  logic [9:0]       pedal_sample;

  modport source(output valid, output column, output row_bits, output pedal_sample,
                 input ready);
  modport sink(input valid, input column, input row_bits, input pedal_sample,
               output ready);
endinterface

interface kms_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [4:0] channel;
  logic [6:0] number;
  logic [6:0] value;
  logic       last;

  modport source(output valid, output event_kind, output channel, output number,
                 output value, output last, input ready);
  modport sink(input valid, input event_kind, input channel, input number,
               input value, input last, output ready);
endinterface

>>> hdl/kms_front.sv
// Front end: takes scan steps, compares them to the key store and the pedal,
// and queues the changes in emission order. Depends on kms_pkg and kms_if.
module kms_front
  import kms_pkg::*;
#(
  parameter int MANUALS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  kms_in_if.sink         in_ch,
  input  logic [9:0]     deadband,
  input  logic           q_full,
  output logic           q_push,
  output q_entry_t       q_data
);

  localparam int ROW_W = LINES_PER_MAN * MANUALS;

  // Key store: one row per column, one bit per present data line
  logic [ROW_W-1:0] key_row_r [COLUMNS];
  logic [9:0]       last_pedal_r;

  logic             accept;
  logic [ROW_W-1:0] old_row;
  logic [ROW_W-1:0] new_row;
  logic [LINES-1:0] chg;
  logic [LINES-1:0] rows_ext;
  logic [9:0]       pdiff;
  logic             pedal_evt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Compare against stored levels
  assign old_row  = key_row_r[in_ch.column];
  assign new_row  = in_ch.row_bits[ROW_W-1:0];
  assign chg      = LINES'(old_row ^ new_row);
  assign rows_ext = LINES'(new_row);

  // Pedal moves only count beyond the deadband
  assign pdiff     = (in_ch.pedal_sample >= last_pedal_r) ?
                     in_ch.pedal_sample - last_pedal_r :
                     last_pedal_r - in_ch.pedal_sample;
  assign pedal_evt = pdiff > deadband;

  // Reorder changes into key/manual order for this column
  always_comb begin
    q_data.col       = in_ch.column;
    q_data.pedal_evt = pedal_evt;
    q_data.cc_value  = in_ch.pedal_sample[9:3];
    for (int s = 0; s < LINES; s++) begin
      q_data.mask[s]  = chg[LINE_TAB[in_ch.column][s]];
      q_data.level[s] = rows_ext[LINE_TAB[in_ch.column][s]];
    end
  end

  // Queue only steps that produce at least one event
  assign q_push = accept && ((|chg) || pedal_evt);

  // Update stored state on every accepted step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMNS; c++) key_row_r[c] <= '0;
      last_pedal_r <= '0;
    end else if (accept) begin
      key_row_r[in_ch.column] <= new_row;
      if (pedal_evt) last_pedal_r <= in_ch.pedal_sample;
    end
  end

endmodule

>>> hdl/kms_fifo.sv
// Two-entry queue between the front end and the event builder.
// Depends on kms_pkg for the entry type.
module kms_fifo
  import kms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full       = count_r == (PTR_W+1)'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  // Write entries
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && head_valid) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push && !full, pop && head_valid})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/kms_back.sv
// Event builder: walks one queued step, one event per cycle while the output
// is taken, into an output register. Depends on kms_pkg and kms_if.
module kms_back
  import kms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     head_valid,
  input  q_entry_t head,
  output logic     pop,
  kms_out_if.source out_ch
);

  logic     busy_r, busy_nxt;
  q_entry_t cur_r, cur_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [4:0] chan_r, chan_nxt;
  logic [6:0] num_r, num_nxt;
  logic [6:0] val_r, val_nxt;
  logic       last_r, last_nxt;

  logic              can_emit;
  logic [LINE_W-1:0] slot;
  logic [LINE_W-1:0] line;
  logic [1:0]        man;
  logic [2:0]        kbit;
  logic [KEY_W-1:0]  key;
  logic [LINES-1:0]  rem;
  logic              lvl;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign pop      = !busy_r && head_valid;

  // Lowest pending slot
  always_comb begin
    slot = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) slot = LINE_W'(i);
    end
  end

  // Map slot to manual and key index
  assign line = LINE_TAB[cur_r.col][slot];
  assign man  = line[4:3];
  assign kbit = line[2:0];
  assign key  = (man == MAN_COLWISE) ? {cur_r.col, kbit} : {kbit, cur_r.col};
  assign rem  = cur_r.mask & ~(LINES'(1) << slot);
  assign lvl  = cur_r.level[slot];

  // Load, emit, finish
  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    chan_nxt      = chan_r;
    num_nxt       = num_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    if (pop) begin
      cur_nxt  = head;
      busy_nxt = 1'b1;
    end else if (busy_r && can_emit) begin
      out_valid_nxt = 1'b1;
      if (|cur_r.mask) begin
        kind_nxt     = lvl ? EV_NOTE_ON : EV_NOTE_OFF;
        chan_nxt     = 5'(man) + 5'd1;
        num_nxt      = cfg.base_note + 7'(key);
        val_nxt      = lvl ? cfg.on_velocity : 7'd0;
        last_nxt     = (rem == '0) && !cur_r.pedal_evt;
        cur_nxt.mask = rem;
        busy_nxt     = !last_nxt;
      end else begin
        kind_nxt = EV_CC;
        chan_nxt = cfg.cc_channel;
        num_nxt  = cfg.cc_number;
        val_nxt  = cur_r.cc_value;
        last_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kind_r <= kind_nxt;
    chan_r <= chan_nxt;
    num_r  <= num_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = kind_r;
  assign out_ch.channel    = chan_r;
  assign out_ch.number     = num_r;
  assign out_ch.value      = val_r;
  assign out_ch.last       = last_r;

endmodule

>>> hdl/key_matrix_note_event_scanner.sv
// Key matrix scanner top: register port, front end, queue and event builder.
// Depends on kms_pkg, kms_if, kms_front, kms_fifo and kms_back.
//
// Each input item is one column of the 8 x 32 key matrix plus a pedal sample.
// The front end takes an item every cycle while its two-entry queue has room,
// updates the key store and pedal level at once, and queues the step only if
// it causes events. The event builder loads a queued step and then delivers
// one event per cycle while the output is taken; it loads the next step only
// once the current one is done, so it sets the sustained rate. Steps that
// cause no event never reach the queue or the event builder.
// Events come in ascending key index, manual order within a key, then the
// optional pedal control change; the final event of a step has last set.
// Registers sit at byte addresses 0, 4, 8, 12, 16; unused high bits read 0.
module key_matrix_note_event_scanner
  import kms_pkg::*;
#(
  parameter int MANUALS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  kms_in_if.sink      in_item,
  kms_out_if.source   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] base_note_r;
  logic [6:0] on_vel_r;
  logic [6:0] cc_number_r;
  logic [4:0] cc_channel_r;
  logic [9:0] deadband_r;

  logic       wr_en;
  logic [2:0] reg_idx;
  cfg_t       cfg;

  logic     q_push;
  q_entry_t q_data;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_note_r  <= RST_BASE_NOTE;
      on_vel_r     <= RST_ON_VEL;
      cc_number_r  <= RST_CC_NUMBER;
      cc_channel_r <= RST_CC_CHANNEL;
      deadband_r   <= RST_DEADBAND;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_NOTE:  base_note_r  <= pwdata[6:0];
        REG_ON_VEL:     on_vel_r     <= pwdata[6:0];
        REG_CC_NUMBER:  cc_number_r  <= pwdata[6:0];
        REG_CC_CHANNEL: cc_channel_r <= pwdata[4:0];
        REG_DEADBAND:   deadband_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_BASE_NOTE:  prdata = 32'(base_note_r);
      REG_ON_VEL:     prdata = 32'(on_vel_r);
      REG_CC_NUMBER:  prdata = 32'(cc_number_r);
      REG_CC_CHANNEL: prdata = 32'(cc_channel_r);
      REG_DEADBAND:   prdata = 32'(deadband_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.base_note   = base_note_r;
  assign cfg.on_velocity = on_vel_r;
  assign cfg.cc_number   = cc_number_r;
  assign cfg.cc_channel  = cc_channel_r;

  kms_front #(
    .MANUALS(MANUALS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_item),
    .deadband(deadband_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  kms_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  kms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_ch    (out_item)
  );

endmodule
